@@ hdl/fdcr_pkg.sv @@
// Package with the access codes, command codes, status values and header CRC constants.
`default_nettype none

package fdcr_pkg;

    // Bus access kinds carried with each input item.
    typedef enum logic [3:0] {
        ACC_RD_STATUS   = 4'd0,
        ACC_RD_DATA     = 4'd1,
        ACC_RD_IFACE    = 4'd2,
        ACC_WR_CMD      = 4'd3,
        ACC_WR_DATA     = 4'd4,
        ACC_WR_CONTROL  = 4'd5,
        ACC_WR_TRACK    = 4'd6,
        ACC_WR_SECTOR   = 4'd7,
        ACC_RD_TRACK    = 4'd8,
        ACC_RD_SECTOR   = 4'd9,
        ACC_FILL        = 4'd10
    } t_access;

    // Controller commands, taken from the high nibble of a command write.
    typedef enum logic [3:0] {
        CMD_RESTORE   = 4'd0,
        CMD_SEEK      = 4'd1,
        CMD_RD_SECTOR = 4'd8,
        CMD_RD_ADDR   = 4'd12,
        CMD_FORCE_INT = 4'd13
    } t_cmd;

    // Configuration register indexes.
    localparam logic [1:0] CFG_MAX_TRACKS  = 2'd0;
    localparam logic [1:0] CFG_MAX_SECTORS = 2'd1;
    localparam logic [1:0] CFG_IMAGE       = 2'd2;

    // Status register values.
    localparam logic [6:0] ST_TRACK0       = 7'd4;
    localparam logic [6:0] ST_NONE         = 7'd0;
    localparam logic [6:0] ST_RESTORE_OK   = 7'd36;
    localparam logic [6:0] ST_RESTORE_FAIL = 7'd60;
    localparam logic [6:0] ST_SEEK_OK      = 7'd32;
    localparam logic [6:0] ST_SEEK_FAIL    = 7'd56;
    localparam logic [6:0] ST_RNF          = 7'd16;
    localparam logic [6:0] ST_UNKNOWN      = 7'd92;

    // Interface status pieces.
    localparam logic [7:0] IF_IRQ_SET   = 8'h3E;
    localparam logic [7:0] IF_IRQ_CLEAR = 8'h3C;
    localparam logic [7:0] IF_FIXED     = 8'h40;

    localparam logic [15:0] CRC_POLY = 16'h1021;
    localparam logic [15:0] CRC_SEED = 16'hB230;

    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
        logic [15:0] c;
        logic [7:0]  v;
        c = crc_in;
        v = b;
        for (int k = 0; k < 8; k++) begin
            if (v[7] ^ c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
            v = {v[6:0], 1'b0};
        end
        return c;
    endfunction

    // CRC over the first four ID header bytes: track, side, 1, 2.
    function automatic logic [15:0] hdr_crc(input logic [7:0] trk, input logic side);
        logic [15:0] c;
        c = crc_byte(CRC_SEED, trk);
        c = crc_byte(c, {7'd0, side});
        c = crc_byte(c, 8'd1);
        c = crc_byte(c, 8'd2);
        return c;
    endfunction

    // The CRC is affine in the message bits, so the header CRC is a base value
    // plus one XOR term per set track bit and one for the side bit.
    function automatic logic [7:0][15:0] crc_track_terms();
        logic [7:0][15:0] terms;
        for (int i = 0; i < 8; i++) begin
            terms[i] = hdr_crc(8'(1 << i), 1'b0) ^ hdr_crc(8'd0, 1'b0);
        end
        return terms;
    endfunction

    localparam logic [15:0]      CRC_BASE = hdr_crc(8'd0, 1'b0);
    localparam logic [15:0]      CRC_SIDE = hdr_crc(8'd0, 1'b1) ^ CRC_BASE;
    localparam logic [7:0][15:0] CRC_TRK  = crc_track_terms();

endpackage

`default_nettype wire

@@ hdl/floppy_controller_registers_core.sv @@
// Floppy controller register core: bus access execution over a sector store memory.
// Pipeline: an accepted item is held in the execute register, its result in the output
// register. Throughput: one item per cycle unless the output stalls; the sector store
// is read every cycle at the forwarded next store position, so a data read follows
// any access without a bubble.
// Reset: synchronous, active low; resets all control and configuration registers.
// The sector store is not cleared and holds unknown bytes until filled.
`default_nettype none

module floppy_controller_registers_core #(
    parameter int SECTOR_BYTES = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_wr_en,
    input  wire logic [1:0]  i_cfg_index,
    input  wire logic [7:0]  i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // tdata: bus_value [7:0], fill_index [16:8], zero [23:17]
    input  wire logic [23:0] s_axis_tdata,
    // tuser: access kind [3:0]
    input  wire logic [3:0]  s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // tdata: read_data [7:0], irq_active [8], drq_active [9], sector_request [10],
    // sector_number [27:11], zero [31:28]
    output logic [31:0]      m_axis_tdata
);
    import fdcr_pkg::*;

    localparam int AW    = $clog2(SECTOR_BYTES);
    localparam int LEN_W = $clog2(SECTOR_BYTES + 1);
    localparam logic [10:0] SB11 = 11'(SECTOR_BYTES);
    localparam int HDR_N = 6;

    // Configuration.
    logic [7:0] r_max_tracks, r_max_sectors;
    logic       r_image;

    // Execute stage.
    logic       r_s1_valid;
    t_access    r_s1_acc;
    logic [7:0] r_s1_val;
    logic [8:0] r_s1_idx;
    logic       exec;

    // Output register.
    logic        r_out_valid;
    logic [31:0] r_out_data;

    // Controller state.
    logic [7:0]       r_track, n_track;
    logic [7:0]       r_sector, n_sector;
    logic [6:0]       r_status, n_status;
    logic [7:0]       r_data, n_data;
    logic             r_irq, n_irq;
    logic             r_drq, n_drq;
    logic             r_drv_sel, n_drv_sel;
    logic             r_side, n_side;
    logic             r_no_disk, n_no_disk;
    logic [9:0]       r_store_pos, n_store_pos;
    logic [LEN_W-1:0] r_store_len, n_store_len;
    logic             r_zero_fill, n_zero_fill;
    logic [7:0]       r_hdr [HDR_N];
    logic [7:0]       n_hdr [HDR_N];
    logic [HDR_N-1:0] r_hdr_vld, n_hdr_vld;

    // Sector store.
    logic [7:0]    mem [SECTOR_BYTES];
    logic [7:0]    r_mem_q;
    logic          r_byp_vld;
    logic [7:0]    r_byp_data;
    logic [AW-1:0] rd_addr, wr_addr;
    logic          mem_we;
    logic [9:0]    idx10;

    // Execute results.
    logic [7:0]  rd;
    logic        req;
    logic [16:0] num;
    logic [16:0] prod;
    logic [15:0] crc;
    logic [7:0]  store_byte;
    logic [9:0]  pos_inc;
    logic [7:0]  seek_track;
    logic        seek_ok;
    logic        sec_bad;

    assign exec          = r_s1_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || exec;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

    assign idx10   = {1'b0, r_s1_idx};
    assign wr_addr = idx10[AW-1:0];
    assign mem_we  = exec && (r_s1_acc == ACC_FILL) && ({2'b00, r_s1_idx} < SB11);
    assign rd_addr = n_store_pos[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[wr_addr] <= r_s1_val;
        end
        r_mem_q    <= mem[rd_addr];
        r_byp_data <= r_s1_val;
    end

    // A write in the same cycle as the read of that entry is forwarded.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp_vld <= 1'b0;
        end else begin
            r_byp_vld <= mem_we && (wr_addr == rd_addr);
        end
    end

    // Header CRC from the precomputed per-bit terms.
    always_comb begin
        crc = CRC_BASE ^ (r_side ? CRC_SIDE : 16'd0);
        for (int i = 0; i < 8; i++) begin
            if (r_track[i]) begin
                crc = crc ^ CRC_TRK[i];
            end
        end
    end

    assign prod       = 17'({r_track, r_side} * r_max_sectors);
    assign pos_inc    = r_store_pos + 10'd1;
    assign seek_ok    = (r_data < r_max_tracks) && r_drv_sel;
    assign seek_track = seek_ok ? r_data : r_track;
    assign sec_bad    = !r_image || (r_sector == 8'd0) || (r_sector > r_max_sectors)
                        || (r_track >= r_max_tracks);

    always_comb begin
        if (r_zero_fill || ({1'b0, r_store_pos} >= SB11)) begin
            store_byte = 8'd0;
        end else if ((r_store_pos < 10'(HDR_N)) && r_hdr_vld[r_store_pos[2:0]]) begin
            store_byte = r_hdr[r_store_pos[2:0]];
        end else if (r_byp_vld) begin
            store_byte = r_byp_data;
        end else begin
            store_byte = r_mem_q;
        end
    end

    always_comb begin
        n_track     = r_track;
        n_sector    = r_sector;
        n_status    = r_status;
        n_data      = r_data;
        n_irq       = r_irq;
        n_drq       = r_drq;
        n_drv_sel   = r_drv_sel;
        n_side      = r_side;
        n_no_disk   = r_no_disk;
        n_store_pos = r_store_pos;
        n_store_len = r_store_len;
        n_zero_fill = r_zero_fill;
        n_hdr       = r_hdr;
        n_hdr_vld   = r_hdr_vld;
        rd          = 8'd0;
        req         = 1'b0;
        num         = 17'd0;
        if (exec) begin
            case (r_s1_acc)
                ACC_RD_STATUS: begin
                    n_irq = 1'b0;
                    rd    = {1'b1, r_status} | {6'd0, r_drq, 1'b0};
                end
                ACC_RD_DATA: begin
                    if (r_drq) begin
                        n_data      = store_byte;
                        n_store_pos = pos_inc;
                        if (11'(pos_inc) >= 11'(r_store_len)) begin
                            n_drq = 1'b0;
                        end
                    end
                    rd = n_data;
                end
                ACC_RD_IFACE: begin
                    rd = (r_irq ? IF_IRQ_SET : IF_IRQ_CLEAR) | {r_drq, 7'd0} | IF_FIXED
                         | {7'd0, r_no_disk};
                end
                ACC_WR_CMD: begin
                    n_drq = 1'b0;
                    n_irq = 1'b1;
                    case (t_cmd'(r_s1_val[7:4]))
                        CMD_RESTORE: begin
                            if (r_drv_sel) begin
                                n_status = ST_RESTORE_OK;
                                n_track  = 8'd0;
                            end else begin
                                n_status = ST_RESTORE_FAIL;
                            end
                        end
                        CMD_SEEK: begin
                            n_track  = seek_track;
                            n_status = (seek_ok ? ST_SEEK_OK : ST_SEEK_FAIL)
                                       | ((seek_track == 8'd0) ? ST_TRACK0 : ST_NONE);
                        end
                        CMD_RD_SECTOR: begin
                            n_store_pos = 10'd0;
                            n_store_len = LEN_W'(SECTOR_BYTES);
                            if (!r_drv_sel) begin
                                n_zero_fill = 1'b1;
                                n_status    = ST_NONE;
                                n_drq       = 1'b1;
                            end else begin
                                n_zero_fill = 1'b0;
                                if (sec_bad) begin
                                    n_status = ST_RNF;
                                end else begin
                                    req      = 1'b1;
                                    num      = prod + {9'd0, r_sector} - 17'd1;
                                    n_status = ST_NONE;
                                    n_drq    = 1'b1;
                                end
                            end
                        end
                        CMD_RD_ADDR: begin
                            if (r_drv_sel) begin
                                n_hdr[0]    = r_track;
                                n_hdr[1]    = {7'd0, r_side};
                                n_hdr[2]    = 8'd1;
                                n_hdr[3]    = 8'd2;
                                n_hdr[4]    = crc[15:8];
                                n_hdr[5]    = crc[7:0];
                                n_hdr_vld   = '1;
                                n_sector    = r_track;
                                n_zero_fill = 1'b0;
                                n_drq       = 1'b1;
                                n_store_len = LEN_W'(HDR_N);
                                n_store_pos = 10'd0;
                                n_status    = ST_NONE;
                            end else begin
                                n_status = ST_RNF;
                            end
                        end
                        CMD_FORCE_INT: begin
                            n_irq    = (r_s1_val[3:0] != 4'd0);
                            n_status = (r_track == 8'd0) ? ST_TRACK0 : ST_NONE;
                        end
                        default: begin
                            n_status = ST_UNKNOWN;
                        end
                    endcase
                end
                ACC_WR_DATA: begin
                    n_data = r_s1_val;
                end
                ACC_WR_CONTROL: begin
                    n_drv_sel = r_image && (r_s1_val[3:0] == 4'd1);
                    n_side    = r_s1_val[4];
                    n_no_disk = !n_drv_sel;
                end
                ACC_WR_TRACK: begin
                    n_track = r_s1_val;
                end
                ACC_WR_SECTOR: begin
                    n_sector = r_s1_val;
                end
                ACC_RD_TRACK: begin
                    rd = r_track;
                end
                ACC_RD_SECTOR: begin
                    rd = r_sector;
                end
                ACC_FILL: begin
                    // A fill over a header byte hands that position back to the store.
                    if (r_s1_idx < 9'(HDR_N)) begin
                        n_hdr_vld[r_s1_idx[2:0]] = 1'b0;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdr <= n_hdr;
        if (s_axis_tvalid && s_axis_tready) begin
            r_s1_acc <= t_access'(s_axis_tuser);
            r_s1_val <= s_axis_tdata[7:0];
            r_s1_idx <= s_axis_tdata[16:8];
        end
        if (exec) begin
            r_out_data <= {4'd0, num, req, n_drq, n_irq, rd};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_tracks  <= 8'd80;
            r_max_sectors <= 8'd9;
            r_image       <= 1'b0;
            r_s1_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_track       <= 8'd0;
            r_sector      <= 8'd0;
            r_status      <= ST_TRACK0;
            r_data        <= 8'd0;
            r_irq         <= 1'b0;
            r_drq         <= 1'b0;
            r_drv_sel     <= 1'b0;
            r_side        <= 1'b0;
            r_no_disk     <= 1'b1;
            r_store_pos   <= 10'd0;
            r_store_len   <= LEN_W'(1);
            r_zero_fill   <= 1'b0;
            r_hdr_vld     <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_MAX_TRACKS:  r_max_tracks  <= i_cfg_data;
                    CFG_MAX_SECTORS: r_max_sectors <= i_cfg_data;
                    CFG_IMAGE:       r_image       <= i_cfg_data[0];
                    default: begin
                    end
                endcase
            end
            if (s_axis_tready) begin
                r_s1_valid <= s_axis_tvalid;
            end
            r_out_valid <= exec || (r_out_valid && !m_axis_tready);
            r_track     <= n_track;
            r_sector    <= n_sector;
            r_status    <= n_status;
            r_data      <= n_data;
            r_irq       <= n_irq;
            r_drq       <= n_drq;
            r_drv_sel   <= n_drv_sel;
            r_side      <= n_side;
            r_no_disk   <= n_no_disk;
            r_store_pos <= n_store_pos;
            r_store_len <= n_store_len;
            r_zero_fill <= n_zero_fill;
            r_hdr_vld   <= n_hdr_vld;
        end
    end

`ifndef ASSERT_OFF
    // A sector request always leaves a data request pending.
    a_req_drq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out_data[10] |-> r_out_data[9])
        else $error("sector request without DRQ");

    // The sector number is only given with a request.
    a_num_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out_data[10] |-> (r_out_data[27:11] == 17'd0))
        else $error("sector number without request");

    // A read address command on a selected drive marks the whole header valid.
    a_hdr_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && $past(exec) && ($past(r_s1_acc) == ACC_WR_CMD)
        && ($past(r_s1_val[7:4]) == CMD_RD_ADDR) && $past(r_drv_sel)
        |-> (r_hdr_vld == '1))
        else $error("header not valid after read address");

    // Bypass data only follows a store write.
    a_byp_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) && r_byp_vld |-> $past(mem_we))
        else $error("bypass without write");
`endif

endmodule

`default_nettype wire
